// ===== rtl/sbd_pkg.sv =====
// shared types, constants and control structs of the serial clock divider search
// no dependencies
`timescale 1ns / 1ps

package sbd_pkg;

  localparam int DATA_W      = 32;
  localparam int STEPS       = 16;
  localparam int CODE_W      = $clog2(STEPS);
  localparam int DIV_W       = CODE_W + 1;
  localparam int BIT_CNT_W   = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] rate_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [DIV_W-1:0]  dvsr_t;
  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

  localparam rate_t ALL_ONES      = '1;
  localparam rate_t SRC_CLK_RESET = rate_t'(60000000);
  localparam code_t CODE_LAST     = code_t'(STEPS - 1);
  localparam bit_cnt_t BIT_LAST   = bit_cnt_t'(DATA_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic scan_step;
    logic code_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic code_last;
    logic hit;
    logic out_busy;
  } dp_flags_t;

endpackage

// ===== rtl/sbd_in_if.sv =====
// request channel carrying one requested serial clock rate
// depends on sbd_pkg
`timescale 1ns / 1ps

interface sbd_in_if import sbd_pkg::*; ();
  logic  valid;
  logic  ready;
  rate_t target_rate_hz;

  modport source (output valid, output target_rate_hz, input ready);
  modport sink (input valid, input target_rate_hz, output ready);
endinterface

// ===== rtl/sbd_out_if.sv =====
// result channel carrying the chosen pre and post divider settings
// depends on sbd_pkg
`timescale 1ns / 1ps

interface sbd_out_if import sbd_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t pre_divider_code;
  code_t post_divider_exponent;

  modport source (output valid, output pre_divider_code, output post_divider_exponent,
                  input ready);
  modport sink (input valid, input pre_divider_code, input post_divider_exponent,
                output ready);
endinterface

// ===== rtl/sbd_cfg_if.sv =====
// configuration write channel for the source clock frequency register
// depends on sbd_pkg
`timescale 1ns / 1ps

interface sbd_cfg_if import sbd_pkg::*; ();
  logic  valid;
  logic  ready;
  rate_t source_clock_hz;

  modport source (output valid, output source_clock_hz, input ready);
  modport sink (input valid, input source_clock_hz, output ready);
endinterface

// ===== rtl/spi_baud_divider_search_unit.sv =====
// top level of the serial clock divider search: controller plus datapath
// depends on sbd_pkg, sbd_in_if, sbd_out_if, sbd_cfg_if, sbd_ctrl, sbd_dp
`timescale 1ns / 1ps

// Finds the pre-divider code (divide by 1..16) and power-of-two post exponent
// (0..15) whose rate, floor(source / pre) >> exponent, lies closest to the
// requested rate; ties keep the lowest code, then the lowest exponent, and an
// exact match ends the search at once. One request is worked on at a time.
// Each pre-divider runs through the bit-serial divider (one quotient bit per
// cycle) and then through the error compares (one exponent per cycle), one
// pre-divider after another. The result sits in an output register, so a new
// request is taken while the previous result still waits. The source clock
// register resets to 60 MHz and is always ready for writes; write it only
// while no request is in flight.

module spi_baud_divider_search_unit import sbd_pkg::*; (
  input logic clk,
  input logic rst_n,
  sbd_in_if.sink    in_req,
  sbd_out_if.source out_res,
  sbd_cfg_if.sink   cfg_wr
);

  cmd_t      cmd;
  dp_flags_t status;
  logic      in_ready;
  logic      out_valid;
  code_t     out_code;
  code_t     out_exp;

  assign in_req.ready = in_ready;
  assign cfg_wr.ready = 1'b1;
  assign out_res.valid = out_valid;
  assign out_res.pre_divider_code = out_code;
  assign out_res.post_divider_exponent = out_exp;

  sbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sbd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .target_rate_hz (in_req.target_rate_hz),
    .cfg_we         (cfg_wr.valid),
    .cfg_data       (cfg_wr.source_clock_hz),
    .out_valid      (out_valid),
    .out_ready      (out_res.ready),
    .out_code       (out_code),
    .out_exp        (out_exp)
  );

  // a request in work blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while previous one still in work");

  // a result is never loaded over one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_res.valid && !out_res.ready))
    else $error("pending result overwritten");

  // a divide step never shares a cycle with a scan step, a result load or request acceptance
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !cmd.scan_step && !cmd.out_load && !in_req.ready)
    else $error("divider step overlaps another phase");

endmodule

// ===== rtl/sbd_ctrl.sv =====
// controller state machine sequencing divide, scan and result phases per request
// depends on sbd_pkg
`timescale 1ns / 1ps

module sbd_ctrl import sbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_flags_t status,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_last) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.hit || (status.scan_last && status.code_last)) begin
          state_nxt = S_OUT;
        end else if (status.scan_last) begin
          state_nxt = S_DIV;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last && !status.code_last && !status.hit) begin
          cmd.code_inc  = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      S_OUT: begin
        cmd.out_load = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/sbd_dp.sv =====
// datapath: source clock register, bit-serial divider, error scan and result register
// depends on sbd_pkg
`timescale 1ns / 1ps

module sbd_dp import sbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output dp_flags_t status,
  input  rate_t     target_rate_hz,
  input  logic      cfg_we,
  input  rate_t     cfg_data,
  output logic      out_valid,
  input  logic      out_ready,
  output code_t     out_code,
  output code_t     out_exp
);

  rate_t    src_clk_r,  src_clk_nxt;
  rate_t    target_r,   target_nxt;
  rate_t    dvd_r,      dvd_nxt;
  dvsr_t    rem_r,      rem_nxt;
  bit_cnt_t bit_cnt_r,  bit_cnt_nxt;
  code_t    code_r,     code_nxt;
  code_t    exp_r,      exp_nxt;
  rate_t    best_err_r, best_err_nxt;
  code_t    best_code_r, best_code_nxt;
  code_t    best_exp_r, best_exp_nxt;
  logic     out_valid_r, out_valid_nxt;
  code_t    out_code_r, out_code_nxt;
  code_t    out_exp_r,  out_exp_nxt;

  dvsr_t              divisor;
  logic [DIV_W:0]     rem_sh;
  logic               q_bit;
  rate_t              err;

  assign divisor = dvsr_t'(code_r) + dvsr_t'(1);
  assign rem_sh  = {rem_r, dvd_r[DATA_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, divisor});
  assign err     = (dvd_r > target_r) ? (dvd_r - target_r) : (target_r - dvd_r);

  always_comb begin
    src_clk_nxt   = cfg_we ? cfg_data : src_clk_r;
    target_nxt    = target_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    code_nxt      = code_r;
    exp_nxt       = exp_r;
    best_err_nxt  = best_err_r;
    best_code_nxt = best_code_r;
    best_exp_nxt  = best_exp_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_code_nxt  = out_code_r;
    out_exp_nxt   = out_exp_r;

    if (cmd.load) begin
      target_nxt    = target_rate_hz;
      code_nxt      = '0;
      best_err_nxt  = ALL_ONES;
      best_code_nxt = '0;
      best_exp_nxt  = '0;
    end
    if (cmd.code_inc) begin
      code_nxt = code_r + code_t'(1);
    end
    if (cmd.div_start) begin
      dvd_nxt     = src_clk_r;
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      exp_nxt     = '0;
    end
    if (cmd.div_step) begin
      // restoring division, one quotient bit per cycle
      rem_nxt     = q_bit ? DIV_W'(rem_sh - {1'b0, divisor}) : DIV_W'(rem_sh);
      dvd_nxt     = {dvd_r[DATA_W-2:0], q_bit};
      bit_cnt_nxt = bit_cnt_r + bit_cnt_t'(1);
    end
    if (cmd.scan_step) begin
      if (err < best_err_r) begin
        best_err_nxt  = err;
        best_code_nxt = code_r;
        best_exp_nxt  = exp_r;
      end
      if (!cmd.div_start) begin
        dvd_nxt = dvd_r >> 1;
        exp_nxt = exp_r + code_t'(1);
      end
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = best_code_nxt;
      out_exp_nxt   = best_exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_clk_r   <= SRC_CLK_RESET;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      code_r      <= '0;
      exp_r       <= '0;
    end else begin
      src_clk_r   <= src_clk_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      code_r      <= code_nxt;
      exp_r       <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    best_err_r  <= best_err_nxt;
    best_code_r <= best_code_nxt;
    best_exp_r  <= best_exp_nxt;
    out_code_r  <= out_code_nxt;
    out_exp_r   <= out_exp_nxt;
  end

  always_comb begin
    status.div_last  = (bit_cnt_r == BIT_LAST);
    status.scan_last = (exp_r == CODE_LAST);
    status.code_last = (code_r == CODE_LAST);
    status.hit       = (err == '0);
    status.out_busy  = out_valid_r & ~out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_exp   = out_exp_r;

endmodule
